>>> rtl/rrp_pkg.sv
// Shared types and constants for the RAW10/RAW12 pixel packer.
package rrp_pkg;

   localparam int PIXEL_W             = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [2:0] RAW10_BYTES = 3'd5;
   localparam logic [2:0] RAW12_BYTES = 3'd3;
   localparam logic [3:0] LOW_NIBBLE  = 4'hF;
   localparam logic [1:0] LOW_PAIR    = 2'd3;

   typedef enum logic [0:0] {
      CSR_PACK_MODE = 1'b0
   } csr_index_type;

   typedef enum logic {
      MODE_RAW10 = 1'b0,
      MODE_RAW12 = 1'b1
   } pack_mode_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type pixel;
      logic      frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
      logic [7:0] byte_4;
      logic [2:0] byte_count;
      logic       group_is_last;
   } rsp_payload_type;

   typedef struct packed {
      pixel_type [3:0] px;
      pack_mode_type   mode;
      logic            last;
   } group_type;

   typedef struct packed {
      logic      valid;
      group_type group;
   } group_push_type;

endpackage

>>> rtl/raw10_raw12_pixel_packer.sv
// Top level of the RAW10/RAW12 pixel packer: register port and unit wiring.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/ready     pixel, frame_end
//   rsp_      out        rsp_valid/ready     byte_0..byte_4, byte_count, group_is_last
//   config    in         psel/penable/...    pack_mode at address 0
//
// One pixel is accepted every cycle while the group queue has room; a closed
// group is queued, then moves into the result register once that register is free.
// Throughput is set by the front end's one-pixel-per-cycle accumulator while the queue has room.
// Reset is synchronous and empties the queue, the result register and the open group.
// A stalled result keeps pixels flowing until the queue fills, then req_ready drops.
module raw10_raw12_pixel_packer #(
   parameter int QUEUE_DEPTH = rrp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rrp_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rrp_pkg::rsp_payload_type            rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rrp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [rrp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [rrp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   rrp_pkg::pack_mode_type  mode_ff, mode_in;
   rrp_pkg::csr_index_type  csr_index;
   rrp_pkg::group_push_type push;
   rrp_pkg::group_type      q_group;
   logic                    queue_ready;
   logic                    q_valid;
   logic                    pop;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign csr_index = rrp_pkg::csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in = mode_ff;
      prdata  = '0;
      unique case (csr_index)
         rrp_pkg::CSR_PACK_MODE: begin
            prdata = {{(rrp_pkg::CSR_DATA_W-1){1'b0}}, mode_ff};
            if (csr_write) begin
               mode_in = rrp_pkg::pack_mode_type'(pwdata[0]);
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rrp_pkg::MODE_RAW10;
      end else begin
         mode_ff <= mode_in;
      end
   end

   rrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .mode        (mode_ff),
      .queue_ready (queue_ready),
      .push        (push)
   );

   rrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (queue_ready),
      .pop_valid  (q_valid),
      .pop_group  (q_group),
      .pop        (pop)
   );

   rrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_group   (q_group),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/rrp_front.sv
// Front end: accepts pixels, gathers them into groups and queues closed groups.
module rrp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rrp_pkg::req_payload_type req_data,
   input  rrp_pkg::pack_mode_type   mode,
   input  logic                     queue_ready,
   output rrp_pkg::group_push_type  push
);

   rrp_pkg::pixel_type held_ff [3];
   rrp_pkg::pixel_type held_in [3];
   logic [1:0]         slot_ff;
   logic [1:0]         slot_in;
   logic               accept;
   logic               close;
   rrp_pkg::pixel_type px [4];

   assign req_ready = queue_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // Held entries at and past the slot are always zero.
      for (int k = 0; k < 4; k++) begin
         px[k] = '0;
      end
      if (mode == rrp_pkg::MODE_RAW12) begin
         if (slot_ff == 2'd0) begin
            px[0] = req_data.pixel;
         end else begin
            px[0] = held_ff[0];
            px[1] = req_data.pixel;
         end
         close = req_data.frame_end || (slot_ff != 2'd0);
      end else begin
         for (int k = 0; k < 3; k++) begin
            if (2'(k) < slot_ff) begin
               px[k] = held_ff[k];
            end
         end
         px[slot_ff] = req_data.pixel;
         close = req_data.frame_end || (slot_ff == 2'd3);
      end

      push.valid       = accept && close;
      push.group.px[0] = px[0];
      push.group.px[1] = px[1];
      push.group.px[2] = px[2];
      push.group.px[3] = px[3];
      push.group.mode  = mode;
      push.group.last  = req_data.frame_end;

      held_in = held_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (close) begin
            for (int k = 0; k < 3; k++) begin
               held_in[k] = '0;
            end
            slot_in = 2'd0;
         end else begin
            if (slot_ff != 2'd3) begin
               held_in[slot_ff] = req_data.pixel;
            end
            slot_in = slot_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            held_ff[k] <= '0;
         end
         slot_ff <= 2'd0;
      end else begin
         held_ff <= held_in;
         slot_ff <= slot_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_raw10_full_group_closes : assert property (@(posedge clock) disable iff (reset)
      (accept && mode == rrp_pkg::MODE_RAW10 && slot_ff == 2'd3) |-> push.valid)
      else $error("four pixels in RAW10 did not close a group");
   a_slot_resets_after_push : assert property (@(posedge clock) disable iff (reset)
      push.valid |=> (slot_ff == 2'd0))
      else $error("slot not cleared after a group closed");
`endif

endmodule

>>> rtl/rrp_queue.sv
// Short queue of closed groups between the front and back ends.
module rrp_queue #(
   parameter int DEPTH = rrp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rrp_pkg::group_push_type push,
   output logic                    push_ready,
   output logic                    pop_valid,
   output rrp_pkg::group_type      pop_group,
   input  logic                    pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rrp_pkg::group_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_group  = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready)
      else $error("group pushed into a full queue");
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");
`endif

endmodule

>>> rtl/rrp_back.sv
// Back end: packs queued groups into bytes and holds the result register.
module rrp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  rrp_pkg::group_type       q_group,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rrp_pkg::rsp_payload_type rsp_data
);

   logic                     rsp_valid_ff, rsp_valid_in;
   rrp_pkg::rsp_payload_type rsp_data_ff;
   rrp_pkg::rsp_payload_type packed_rsp;

   function automatic rrp_pkg::rsp_payload_type pack_group(rrp_pkg::group_type g);
      rrp_pkg::rsp_payload_type r;
      logic [7:0]               hi [4];
      logic [7:0]               pairs;
      r     = '0;
      pairs = '0;
      if (g.mode == rrp_pkg::MODE_RAW12) begin
         r.byte_0     = g.px[0][11:4];
         r.byte_1     = g.px[1][11:4];
         r.byte_2     = {g.px[1][3:0] & rrp_pkg::LOW_NIBBLE,
                         g.px[0][3:0] & rrp_pkg::LOW_NIBBLE};
         r.byte_count = rrp_pkg::RAW12_BYTES;
      end else begin
         // Drop bits above the 10-bit pixel.
         for (int k = 0; k < 4; k++) begin
            hi[k] = g.px[k][9:2];
            pairs[2*k +: 2] = g.px[k][1:0] & rrp_pkg::LOW_PAIR;
         end
         r.byte_0     = hi[0];
         r.byte_1     = hi[1];
         r.byte_2     = hi[2];
         r.byte_3     = hi[3];
         r.byte_4     = pairs;
         r.byte_count = rrp_pkg::RAW10_BYTES;
      end
      r.group_is_last = g.last;
      return r;
   endfunction

   assign packed_rsp = pack_group(q_group);
   assign pop        = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= packed_rsp;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_matches_mode : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.byte_count == rrp_pkg::RAW10_BYTES ||
                        rsp_data_ff.byte_count == rrp_pkg::RAW12_BYTES))
      else $error("result byte count is neither RAW10 nor RAW12");
`endif

endmodule
